>>> sv/tzhd_pkg.sv
package tzhd_pkg;

    typedef enum logic [3:0] {
        MODE_PRESS   = 4'd0,
        MODE_MOVE    = 4'd1,
        MODE_RELEASE = 4'd2,
        MODE_ADD     = 4'd3,
        MODE_CLR_ALL = 4'd4,
        MODE_CLR_ONE = 4'd5,
        MODE_FORCE   = 4'd6,
        MODE_FRAME   = 4'd7,
        MODE_QUERY   = 4'd8
    } mode_t;

    localparam logic [2:0] EV_DONE     = 3'd0;
    localparam logic [2:0] EV_PRESSED  = 3'd1;
    localparam logic [2:0] EV_RELEASED = 3'd2;
    localparam logic [2:0] EV_ACTIV    = 3'd3;
    localparam logic [2:0] EV_MOVE     = 3'd4;
    localparam logic [2:0] EV_ADDED    = 3'd5;
    localparam logic [2:0] EV_REJECT   = 3'd6;
    localparam logic [2:0] EV_QUERY    = 3'd7;

    localparam logic [1:0] PS_IDLE    = 2'd0;
    localparam logic [1:0] PS_PRESSED = 2'd1;
    localparam logic [1:0] PS_IGNORE  = 2'd2;

    typedef struct packed {
        logic [3:0]  mode;
        logic [1:0]  touch_id;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] x_far;
        logic signed [15:0] y_far;
        logic [7:0]  zone_label_in;
        logic        track_moves;
        logic        ignore_next;
    } tzhd_in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  zone_label_out;
        logic [3:0]  zone_slot;
        logic [15:0] rel_x;
        logic [15:0] rel_y;
        logic        pressed_hit;
        logic        activated_hit;
        logic        last_item;
    } tzhd_out_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // capture input item, latch touch position
        logic       emit;      // present a result beat
        logic [2:0] kind;      // result kind to emit
        logic       last;      // final beat
        logic       set_ps;    // write press state
        logic [1:0] ps_val;
        logic       set_act;   // capture label as last activated
        logic       wr_add;    // write new zone
        logic       wr_clr;    // write clear edges
        logic       upd_touch; // store last position
        logic       act_clear;
        logic       qacc;      // accumulate query hit
    } tzhd_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic       hit_new;
        logic       hit_old;
        logic       tracks;
        logic       lbl_eq;
        logic [1:0] ps;
    } tzhd_sts_t;

endpackage

>>> sv/tzhd_ram.sv
module tzhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/tzhd_datapath.sv
module tzhd_datapath import tzhd_pkg::*; #(
    parameter int ZONES   = 16,
    parameter int TOUCHES = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tzhd_in_t                 in_item,
    input  tzhd_cmd_t                cmd,
    input  logic [$clog2(ZONES)-1:0] slot,
    input  logic [$clog2(ZONES)-1:0] add_slot,
    output tzhd_sts_t                sts,
    output tzhd_out_t                res
);
    localparam int SW = $clog2(ZONES);
    localparam int TW = (TOUCHES > 1) ? $clog2(TOUCHES) : 1;
    // left, right, top, bottom, label, tracks
    localparam int GW = 16 * 4 + 8 + 1;

    tzhd_in_t item_reg;
    logic [15:0] lx_reg, ly_reg;
    logic [15:0] tlx_reg [TOUCHES];
    logic [15:0] tly_reg [TOUCHES];
    logic [1:0]  ps_reg [ZONES];
    logic [8:0]  act_reg;
    logic        qhit_reg;
    tzhd_out_t   res_reg, res_next;
    logic [TW-1:0] tsel;

    logic          z_we;
    logic [SW-1:0] z_wa;
    logic [GW-1:0] z_wd, z_rd;
    logic signed [15:0] zl, zr, zt, zb;
    logic [7:0] zlab;
    logic       ztr;
    logic [SW-1:0] slot_reg;

    // touch id folded onto the touch table by repeated subtraction
    function automatic logic [TW-1:0] touch_sel(input logic [1:0] id);
        logic [1:0] r;
        r = id;
        for (int k = 0; k < 3; k++) begin
            if (int'(r) >= TOUCHES) r = r - 2'(TOUCHES);
        end
        return TW'(r);
    endfunction

    assign tsel = touch_sel(in_item.touch_id);

    // zone geometry store
    always_comb begin
        z_we = cmd.wr_add | cmd.wr_clr;
        z_wa = cmd.wr_add ? add_slot : slot;
        if (cmd.wr_add) begin
            z_wd = {item_reg.x_pos, item_reg.x_far, item_reg.y_pos, item_reg.y_far,
                    item_reg.zone_label_in, item_reg.track_moves};
        end else begin
            z_wd = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, zlab, ztr};
        end
    end

    tzhd_ram #(.WIDTH(GW), .DEPTH(ZONES)) u_zone (
        .aclk (aclk), .we (z_we), .waddr (z_wa), .wdata (z_wd),
        .raddr (slot), .rdata (z_rd)
    );

    assign {zl, zr, zt, zb, zlab, ztr} = z_rd;

    // hit tests on the zone just read
    always_comb begin
        sts.hit_new = (zl <= item_reg.x_pos) && (item_reg.x_pos <= zr)
                   && (zt <= item_reg.y_pos) && (item_reg.y_pos <= zb);
        sts.hit_old = (zl <= $signed(lx_reg)) && ($signed(lx_reg) <= zr)
                   && (zt <= $signed(ly_reg)) && ($signed(ly_reg) <= zb);
        sts.tracks  = ztr;
        sts.lbl_eq  = (zlab == item_reg.zone_label_in);
        sts.ps      = ps_reg[slot_reg];
    end

    // item capture, touch table, press state, activation
    always_ff @(posedge aclk) begin
        slot_reg <= slot;
        if (cmd.load) begin
            item_reg <= in_item;
            lx_reg   <= tlx_reg[tsel];
            ly_reg   <= tly_reg[tsel];
        end
        if (!aresetn) begin
            for (int i = 0; i < TOUCHES; i++) begin
                tlx_reg[i] <= '0;
                tly_reg[i] <= '0;
            end
            for (int i = 0; i < ZONES; i++) begin
                ps_reg[i] <= PS_IDLE;
            end
            act_reg  <= '0;
            qhit_reg <= 1'b0;
        end else begin
            if (cmd.upd_touch) begin
                tlx_reg[touch_sel(item_reg.touch_id)] <= item_reg.x_pos;
                tly_reg[touch_sel(item_reg.touch_id)] <= item_reg.y_pos;
            end
            if (cmd.set_ps) begin
                ps_reg[slot_reg] <= cmd.ps_val;
            end
            if (cmd.act_clear) begin
                act_reg <= '0;
            end else if (cmd.set_act) begin
                act_reg <= {1'b1, zlab};
            end
            if (cmd.load) begin
                qhit_reg <= 1'b0;
            end else if (cmd.qacc && sts.lbl_eq && sts.ps == PS_PRESSED) begin
                qhit_reg <= 1'b1;
            end
        end
    end

    // result beat contents
    always_comb begin
        res_next = '0;
        res_next.event_kind = cmd.kind;
        res_next.last_item  = cmd.last;
        case (cmd.kind)
            EV_PRESSED, EV_RELEASED, EV_ACTIV: begin
                res_next.zone_label_out = zlab;
                res_next.zone_slot      = 4'(slot_reg);
            end
            EV_MOVE: begin
                res_next.zone_label_out = zlab;
                res_next.zone_slot      = 4'(slot_reg);
                res_next.rel_x          = item_reg.x_pos - zl;
                res_next.rel_y          = item_reg.y_pos - zt;
            end
            EV_ADDED: begin
                res_next.zone_label_out = item_reg.zone_label_in;
                res_next.zone_slot      = 4'(add_slot);
            end
            EV_REJECT: begin
                res_next.zone_label_out = item_reg.zone_label_in;
            end
            EV_QUERY: begin
                res_next.zone_label_out = item_reg.zone_label_in;
                res_next.pressed_hit    = qhit_reg;
                res_next.activated_hit  = act_reg[8]
                    && (act_reg[7:0] == item_reg.zone_label_in);
            end
            default: begin
            end
        endcase
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule

>>> sv/tzhd_ctrl.sv
module tzhd_ctrl import tzhd_pkg::*; #(
    parameter int ZONES = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_mode,
    output logic                     m_valid,
    input  logic                     m_ready,
    input  tzhd_sts_t                sts,
    output tzhd_cmd_t                cmd,
    output logic [$clog2(ZONES)-1:0] slot,
    output logic [$clog2(ZONES)-1:0] add_slot
);
    localparam int SW = $clog2(ZONES);
    localparam int CW = $clog2(ZONES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISP, ST_RD, ST_EVAL, ST_MOVE2, ST_OUT, ST_FINAL, ST_WAIT
    } state_t;

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    logic [3:0]    mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;   // slots left (down scan) or next slot (up)
    logic          pass2_reg, pass2_next;
    logic          mvalid_reg, mvalid_next;
    logic          found_reg, found_next;
    logic [2:0]    fkind_reg, fkind_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic          up_scan;

    assign up_scan  = (mode_reg == MODE_FORCE) || (mode_reg == MODE_QUERY);
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mvalid_reg;
    assign slot     = cur_next;
    assign add_slot = cnt_reg[SW-1:0];

    // sequencer
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pass2_next  = pass2_reg;
        found_next  = found_reg;
        fkind_next  = fkind_reg;
        cur_next    = cur_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    mode_next  = s_mode;
                    pass2_next = 1'b0;
                    found_next = 1'b0;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                fkind_next = EV_DONE;
                state_next = ST_FINAL;
                case (mode_reg) inside
                    MODE_PRESS, MODE_MOVE, MODE_RELEASE, MODE_CLR_ONE: begin
                        idx_next   = cnt_reg;
                        state_next = ST_RD;
                    end
                    MODE_FORCE, MODE_QUERY: begin
                        idx_next   = '0;
                        state_next = ST_RD;
                        if (mode_reg == MODE_QUERY) fkind_next = EV_QUERY;
                    end
                    MODE_ADD: begin
                        if (cnt_reg < CW'(ZONES)) begin
                            cmd.wr_add = 1'b1;
                            fkind_next = EV_ADDED;
                        end else begin
                            fkind_next = EV_REJECT;
                        end
                    end
                    MODE_CLR_ALL: begin
                        cnt_next = '0;
                    end
                    MODE_FRAME: begin
                        cmd.act_clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RD: begin
                // choose the next slot and read it
                if (up_scan) begin
                    if (idx_reg == cnt_reg) begin
                        state_next = ST_FINAL;
                    end else begin
                        cur_next   = idx_reg[SW-1:0];
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EVAL;
                    end
                end else if (idx_reg == '0 || found_reg) begin
                    if (mode_reg == MODE_MOVE && !pass2_reg) begin
                        pass2_next = 1'b1;
                        idx_next   = cnt_reg;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end else begin
                    cur_next   = SW'(idx_reg - 1'b1);
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_RD;
                case (mode_reg)
                    MODE_PRESS: begin
                        if (sts.hit_new) begin
                            cmd.set_ps = 1'b1;
                            cmd.ps_val = PS_PRESSED;
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_PRESSED;
                            state_next = ST_OUT;
                            ret_next   = sts.tracks ? ST_MOVE2 : ST_RD;
                        end
                    end
                    MODE_MOVE: begin
                        if (!pass2_reg && sts.hit_old && !sts.hit_new) begin
                            cmd.set_ps = 1'b1;
                            cmd.ps_val = PS_IDLE;
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_RELEASED;
                            state_next = ST_OUT;
                            ret_next   = ST_RD;
                        end else if (!pass2_reg && sts.hit_old && sts.tracks) begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_MOVE;
                            state_next = ST_OUT;
                            ret_next   = ST_RD;
                        end else if (pass2_reg && sts.hit_new && !sts.hit_old) begin
                            cmd.set_ps = 1'b1;
                            cmd.ps_val = PS_PRESSED;
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_PRESSED;
                            state_next = ST_OUT;
                            ret_next   = ST_RD;
                        end
                    end
                    MODE_RELEASE: begin
                        if (sts.hit_new) begin
                            cmd.set_ps  = 1'b1;
                            cmd.ps_val  = PS_IDLE;
                            cmd.set_act = 1'b1;
                            if (sts.ps != PS_IGNORE) begin
                                cmd.emit   = 1'b1;
                                cmd.kind   = EV_ACTIV;
                                state_next = ST_OUT;
                                ret_next   = ST_RD;
                            end
                        end
                    end
                    MODE_CLR_ONE: begin
                        if (sts.lbl_eq) begin
                            cmd.wr_clr = 1'b1;
                            found_next = 1'b1;
                        end
                    end
                    MODE_FORCE: begin
                        if (sts.ps != PS_IDLE) begin
                            cmd.set_ps = 1'b1;
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_RELEASED;
                            state_next = ST_OUT;
                            ret_next   = ST_RD;
                        end
                    end
                    MODE_QUERY: begin
                        cmd.qacc = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_MOVE2: begin
                // tracked press: follow the pressed beat with a move beat
                if (!mvalid_next) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = EV_MOVE;
                    mvalid_next = 1'b1;
                    state_next  = ST_OUT;
                    ret_next    = ST_RD;
                end
            end
            ST_OUT: begin
                if (!mvalid_next) state_next = ret_reg;
            end
            ST_FINAL: begin
                if (!mvalid_next) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = fkind_reg;
                    cmd.last    = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_WAIT;
                    case (mode_reg)
                        MODE_PRESS, MODE_MOVE: cmd.upd_touch = 1'b1;
                        MODE_FORCE:            cnt_next = '0;
                        MODE_ADD: begin
                            if (fkind_reg == EV_ADDED) cnt_next = cnt_reg + 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                if (!mvalid_next) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_EVAL && cmd.emit) begin
            mvalid_next = 1'b1;
        end
    end

    // the force-release target state comes from the captured item; the
    // datapath keys it off ps_val, which the top overrides
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            mode_reg   <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            pass2_reg  <= 1'b0;
            found_reg  <= 1'b0;
            fkind_reg  <= EV_DONE;
            cur_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            pass2_reg  <= pass2_next;
            found_reg  <= found_next;
            fkind_reg  <= fkind_next;
            cur_reg    <= cur_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // a beat is only raised once the previous one has gone
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(mvalid_reg && !m_ready))
        else $error("result beat overwritten");
    // the zone count never exceeds the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(ZONES))
        else $error("zone count overflow");
    // no new item while a run is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken mid-run");
endmodule

>>> sv/touch_zone_hit_dispatcher.sv
// Touch zone hit dispatcher. Each input beat is one command; it produces a run
// of result beats ending in one with last_item set. Commands take one item at a
// time. A scanning command reads each used slot from the zone store and then
// tests it, emitting result beats as it goes (a tracked press adds a move beat
// after its pressed beat); a move scans the table twice. Result stalls hold the
// scan. The scan rate is set by the single read port of the zone store. No
// clearing pass after reset.
module touch_zone_hit_dispatcher import tzhd_pkg::*; #(
    parameter int ZONES   = 16,
    parameter int TOUCHES = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tzhd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tzhd_out_t m_data
);
    tzhd_cmd_t                cmd_c, cmd;
    tzhd_sts_t                sts;
    logic [$clog2(ZONES)-1:0] slot, add_slot;
    logic                     ign_reg;
    logic                     force_mode;
    logic [3:0]               mode_cap_reg;

    // force release target state depends on the captured ignore flag
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) ign_reg <= s_data.ignore_next;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) mode_cap_reg <= s_data.mode;
    end
    assign force_mode = (mode_cap_reg == MODE_FORCE);

    always_comb begin
        cmd = cmd_c;
        if (cmd_c.set_ps && cmd_c.kind == EV_RELEASED && force_mode) begin
            cmd.ps_val = ign_reg ? PS_IGNORE : PS_IDLE;
        end
    end

    tzhd_ctrl #(.ZONES(ZONES)) u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready), .s_mode (s_data.mode),
        .m_valid (m_valid), .m_ready (m_ready),
        .sts (sts), .cmd (cmd_c), .slot (slot), .add_slot (add_slot)
    );

    tzhd_datapath #(.ZONES(ZONES), .TOUCHES(TOUCHES)) u_dp (
        .aclk (aclk), .aresetn (aresetn), .in_item (s_data),
        .cmd (cmd), .slot (slot), .add_slot (add_slot),
        .sts (sts), .res (m_data)
    );
endmodule
